>>> rtl/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation block.
// Each macro expects clk and arst_n in scope.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication
`define MEXP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define MEXP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

	// Field widths
	localparam int MOD_W  = 31;
	localparam int EXP_W  = 32;
	localparam int PROD_W = 2 * MOD_W;

	// Exponent bits scanned; bits above the port width read as zero
	localparam int EXP_BITS = 32;
	localparam int EXP_USE  = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
	localparam logic [EXP_W-1:0] EXP_MASK = EXP_W'((65'd1 << EXP_USE) - 65'd1);

	// Reduction step counter
	localparam int RED_CNT_W = $clog2(PROD_W + 1);

	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic update;
		logic out_load;
	} mexp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic red_busy;
		logic exp_zero;
		logic mod_zero;
	} mexp_status_t;

endpackage

>>> rtl/mexp_modred.sv
`timescale 1ns / 1ps

// Bit-serial restoring reduction: remainder of a product by the modulus,
// one product bit per cycle, MSB first.
module mexp_modred (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  logic [mexp_pkg::PROD_W-1:0]             product,
	input  logic [mexp_pkg::MOD_W-1:0]              modulus,
	output logic                                    busy,
	output logic [mexp_pkg::MOD_W-1:0]              remainder
);

	logic [mexp_pkg::RED_CNT_W-1:0] cnt_q;
	logic [mexp_pkg::PROD_W-1:0]    sh_q;
	logic [mexp_pkg::MOD_W-1:0]     rem_q;
	logic [mexp_pkg::MOD_W:0]       rem_sh;
	logic [mexp_pkg::MOD_W:0]       mod_ext;
	logic [mexp_pkg::MOD_W:0]       rem_sub;
	logic [mexp_pkg::MOD_W-1:0]     rem_n;

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;

	// One shift-and-subtract step
	assign rem_sh  = {rem_q, sh_q[mexp_pkg::PROD_W-1]};
	assign mod_ext = {1'b0, modulus};
	assign rem_sub = rem_sh - mod_ext;
	assign rem_n   = (rem_sh >= mod_ext) ? rem_sub[mexp_pkg::MOD_W-1:0]
	                                     : rem_sh[mexp_pkg::MOD_W-1:0];

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= mexp_pkg::RED_CNT_W'(mexp_pkg::PROD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - mexp_pkg::RED_CNT_W'(1);
		end
	end

	// Shift register and partial remainder
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= product;
			rem_q <= '0;
		end else if (busy) begin
			sh_q  <= {sh_q[mexp_pkg::PROD_W-2:0], 1'b0};
			rem_q <= rem_n;
		end
	end

endmodule

>>> rtl/mexp_dp.sv
`timescale 1ns / 1ps

module mexp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mexp_pkg::mexp_cmd_t           cmd,
	output mexp_pkg::mexp_status_t        status,
	input  logic                          cfg_we,
	input  logic [mexp_pkg::MOD_W-1:0]    cfg_modulus,
	input  logic [mexp_pkg::MOD_W-1:0]    base_value,
	input  logic [mexp_pkg::EXP_W-1:0]    exponent_value,
	output logic [mexp_pkg::MOD_W-1:0]    power_result
);

	logic [mexp_pkg::MOD_W-1:0]  mod_q;
	logic [mexp_pkg::MOD_W-1:0]  acc_q;
	logic [mexp_pkg::MOD_W-1:0]  pw_q;
	logic [mexp_pkg::EXP_W-1:0]  exp_q;
	logic [mexp_pkg::MOD_W-1:0]  result_q;
	logic [mexp_pkg::MOD_W-1:0]  mul_op;
	logic [mexp_pkg::PROD_W-1:0] prod;
	logic                        busy_a;
	logic                        busy_b;
	logic [mexp_pkg::MOD_W-1:0]  rem_a;
	logic [mexp_pkg::MOD_W-1:0]  rem_b;

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= mexp_pkg::MODULUS_RESET;
		end else if (cfg_we) begin
			mod_q <= cfg_modulus;
		end
	end

	// Shared multiplier: acc * pw, then pw * pw
	assign mul_op = cmd.mul_a ? acc_q : pw_q;
	assign prod   = {{mexp_pkg::MOD_W{1'b0}}, mul_op} * {{mexp_pkg::MOD_W{1'b0}}, pw_q};

	// Reducer for the running result
	mexp_modred u_red_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.mul_a),
		.product   (prod),
		.modulus   (mod_q),
		.busy      (busy_a),
		.remainder (rem_a)
	);

	// Reducer for the squared power
	mexp_modred u_red_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.mul_b),
		.product   (prod),
		.modulus   (mod_q),
		.busy      (busy_b),
		.remainder (rem_b)
	);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= mexp_pkg::MOD_W'(1);
			pw_q  <= base_value;
			exp_q <= exponent_value & mexp_pkg::EXP_MASK;
		end else if (cmd.update) begin
			if (exp_q[0]) begin
				acc_q <= rem_a;
			end
			pw_q  <= rem_b;
			exp_q <= exp_q >> 1;
		end
	end

	// Output word; a zero modulus yields zero
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q <= (mod_q == '0) ? '0 : acc_q;
		end
	end

	assign power_result    = result_q;
	assign status.red_busy = busy_a | busy_b;
	assign status.exp_zero = (exp_q == '0);
	assign status.mod_zero = (mod_q == '0);

endmodule

>>> rtl/mexp_ctrl.sv
`timescale 1ns / 1ps

module mexp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  mexp_pkg::mexp_status_t    status,
	output mexp_pkg::mexp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_A,
		ST_MUL_B,
		ST_WAIT_RED,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.mul_a    = (state_q == ST_MUL_A);
		cmd.mul_b    = (state_q == ST_MUL_B);
		cmd.update   = (state_q == ST_UPDATE) && !status.red_busy;
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.mod_zero || status.exp_zero) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_WAIT_RED;
				ST_WAIT_RED: begin
					if (!status.red_busy) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: state_q <= ST_CHECK;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/modular_exponentiation.sv
`timescale 1ns / 1ps

// Modular exponentiation, right-to-left square-and-multiply.
// Input channel: in_valid / in_stall with base_value and exponent_value; a
//   word is taken at an edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with power_result, held while stalled.
// Config channel: cfg_valid / cfg_ready with modulus; write only while idle.
// One item is worked on at a time. Each exponent bit up to the highest set
//   one takes a check, two passes through the shared 31x31 multiplier, a
//   wait on the bit-serial reducers (62 product bits, one per cycle) and an
//   update.
// A zero exponent gives 1; a zero modulus gives 0.
// The result sits in an output register, so the next word is accepted while
//   a finished result still waits behind out_stall; a new result waits in
//   the controller until the output register is free.
// Reset clears the controller and sets the modulus to 1000000007.
module modular_exponentiation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mexp_pkg::MOD_W-1:0]    modulus,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mexp_pkg::MOD_W-1:0]    base_value,
	input  logic [mexp_pkg::EXP_W-1:0]    exponent_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mexp_pkg::MOD_W-1:0]    power_result
);

	mexp_pkg::mexp_cmd_t    cmd;
	mexp_pkg::mexp_status_t status;

	assign cfg_ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mexp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_modulus    (modulus),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.power_result   (power_result)
	);

	// Checks
`include "modular_exponentiation_assert.svh"

	`MEXP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
	`MEXP_ASSERT_NOW(a_result_from_item, $rose(out_valid), $past(in_stall), "result without item")
	`MEXP_ASSERT_NOW(a_zero_mod, $rose(out_valid) && status.mod_zero, power_result == '0, "not zero")

endmodule
